### hdl/sptt_pkg.sv
// ----------------------------------------------------------------------------
// sptt_pkg: shared types and constants of the sparse polynomial term table
// Beat payload structs, op and status codes, size defaults.
// ----------------------------------------------------------------------------
package sptt_pkg;

  localparam int MaxTermsDefault  = 16;
  localparam int MaxDegreeDefault = 255;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_ADD    = 2'd1,
    OP_REMOVE = 2'd2,
    OP_EVAL   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [31:0] coefficient;
    logic [7:0]         degree;
    logic signed [31:0] point;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
    logic [4:0]         term_total;
  } out_beat_t;

  // token handed cell to cell along the chain
  typedef struct packed {
    logic        act;    // token live at this cell
    logic        done;   // op already served by an earlier cell
    logic [31:0] acc;    // evaluate running sum
  } tok_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_RUN  = 2'd1,
    S_OUT  = 2'd2
  } fsm_t;

endpackage

### hdl/sparse_polynomial_term_table.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_term_table: bounded table of polynomial terms
// Append, add/merge, remove by degree and evaluate over a chain of cells.
// ----------------------------------------------------------------------------
//  channel | dir | payload                 | handshake
//  in      | in  | sptt_pkg::in_beat_t     | in_valid / in_stall
//  out     | out | sptt_pkg::out_beat_t    | out_valid / out_stall
//
// A token walks the cell row one cell per cycle, except while an evaluating
// cell holds it. Append, remove and an add that merges present the result
// after one walk of the row; an add that has to allocate runs a second pass.
// Evaluate holds the token in every stored term's cell while that cell's
// one-step-per-cycle power unit forms x^degree, then adds the term.
// One item at a time; the result sits in an output register until taken, and
// the next beat is taken the cycle after. Reset is synchronous and empties
// the table.
module sparse_polynomial_term_table #(
  parameter int MAX_TERMS  = sptt_pkg::MaxTermsDefault,
  parameter int MAX_DEGREE = sptt_pkg::MaxDegreeDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  sptt_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sptt_pkg::out_beat_t out_data
);

  localparam int CW = $clog2(MAX_TERMS + 1);

  sptt_pkg::fsm_t state, state_next;
  sptt_pkg::in_beat_t cur, cur_next;
  logic [7:0] deg_sat;
  logic pass2, pass2_next, start;
  logic [CW-1:0] count;
  sptt_pkg::tok_t chain [MAX_TERMS+1];
  sptt_pkg::tok_t tok0, tok0_next;
  logic [MAX_TERMS-1:0] valids;
  sptt_pkg::tok_t last;
  sptt_pkg::out_beat_t out_next;

  // MAX_DEGREE of at least 255 never saturates an 8-bit degree
  assign deg_sat = (MAX_DEGREE < 255 && in_data.degree > 8'(MAX_DEGREE))
                 ? 8'(MAX_DEGREE) : in_data.degree;
  assign start = state == sptt_pkg::S_IDLE && in_valid;
  assign chain[0] = tok0;
  assign last = chain[MAX_TERMS];
  // stored terms, settled by the time the token leaves the row
  assign count = CW'($countones(valids));

  genvar g;
  for (g = 0; g < MAX_TERMS; g++) begin : g_cell
    sptt_cell u_cell (
      .clk, .rst,
      .op(cur.op), .coefficient(cur.coefficient), .degree(cur.degree),
      .point(cur.point), .pass2,
      .tok_in(chain[g]), .tok_out(chain[g+1]),
      .valid(valids[g])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      sptt_pkg::S_IDLE: if (in_valid) state_next = sptt_pkg::S_RUN;
      sptt_pkg::S_RUN: begin
        if (last.act && (pass2 || last.done || cur.op == sptt_pkg::OP_EVAL
            || cur.op == sptt_pkg::OP_REMOVE || count == CW'(MAX_TERMS)))
          state_next = sptt_pkg::S_OUT;
      end
      sptt_pkg::S_OUT: if (!out_stall) state_next = sptt_pkg::S_IDLE;
      default: state_next = sptt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = state != sptt_pkg::S_IDLE;
    out_valid = state == sptt_pkg::S_OUT;
  end

  // token launch, pass control and result capture
  always_comb begin
    cur_next   = cur;
    pass2_next = pass2;
    tok0_next  = '0;
    out_next   = out_data;
    if (start) begin
      cur_next        = in_data;
      cur_next.degree = deg_sat;
      pass2_next      = in_data.op == sptt_pkg::OP_APPEND;
      tok0_next       = '{act: 1'b1, done: 1'b0, acc: 32'd0};
    end else if (state == sptt_pkg::S_RUN && last.act) begin
      out_next            = '0;
      out_next.term_total = 5'(count);
      if (cur.op == sptt_pkg::OP_EVAL) out_next.value = last.acc;
      else if (cur.op == sptt_pkg::OP_REMOVE) begin
        if (!last.done) out_next.status = sptt_pkg::ST_NOTFOUND;
      end else if (!last.done && count == CW'(MAX_TERMS))
        out_next.status = sptt_pkg::ST_FULL;
      else if (!last.done) begin
        // no matching degree: second pass allocates a free cell
        pass2_next = 1'b1;
        tok0_next  = '{act: 1'b1, done: 1'b0, acc: 32'd0};
      end
    end
    if (state == sptt_pkg::S_OUT && !out_stall) pass2_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sptt_pkg::S_IDLE;
      tok0  <= '0;
      pass2 <= 1'b0;
    end else begin
      state <= state_next;
      tok0  <= tok0_next;
      pass2 <= pass2_next;
    end
  end

  always_ff @(posedge clk) begin
    cur      <= cur_next;
    out_data <= out_next;
  end

endmodule

### hdl/sptt_cell.sv
// ----------------------------------------------------------------------------
// sptt_cell: one term slot of the chain
// Holds a term; serves the op when the token reaches it; evaluate forms
// x^degree by square-and-multiply, one squaring step per cycle.
// ----------------------------------------------------------------------------
module sptt_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic [1:0]     op,
  input  logic [31:0]    coefficient,
  input  logic [7:0]     degree,
  input  logic [31:0]    point,
  input  logic           pass2,      // second pass: allocation for add/append
  input  sptt_pkg::tok_t tok_in,
  output sptt_pkg::tok_t tok_out,
  output logic           valid
);

  logic [31:0]    coef, coef_next;
  logic [7:0]     deg, deg_next;
  logic           valid_next;
  logic           busy, busy_next;
  logic [31:0]    r, r_next;
  logic [31:0]    b, b_next;
  logic [7:0]     e, e_next;
  logic           pow_done, pow_done_next;   // power ready, scale by coef next
  sptt_pkg::tok_t held, held_next;
  sptt_pkg::tok_t tok_next;
  logic           matched;

  assign matched = valid && deg == degree;

  always_comb begin
    tok_next      = '0;
    valid_next    = valid;
    coef_next     = coef;
    deg_next      = deg;
    busy_next     = busy;
    r_next        = r;
    b_next        = b;
    e_next        = e;
    pow_done_next = pow_done;
    held_next     = held;
    if (busy) begin
      if (!pow_done) begin
        if (e == 8'd0) pow_done_next = 1'b1;
        else begin
          if (e[0]) r_next = r * b;
          b_next = b * b;
          e_next = e >> 1;
        end
      end else begin
        tok_next     = held;
        tok_next.acc = held.acc + coef * r;
        busy_next    = 1'b0;
      end
    end else if (tok_in.act) begin
      tok_next = tok_in;
      if (op == sptt_pkg::OP_EVAL) begin
        if (valid) begin
          // hold the token while the power is formed
          busy_next     = 1'b1;
          pow_done_next = 1'b0;
          held_next     = tok_in;
          r_next        = 32'd1;
          b_next        = point;
          e_next        = deg;
          tok_next      = '0;
        end
      end else if (!tok_in.done) begin
        if (pass2) begin
          if (!valid) begin
            valid_next    = 1'b1;
            coef_next     = coefficient;
            deg_next      = degree;
            tok_next.done = 1'b1;
          end
        end else if (matched && op != sptt_pkg::OP_APPEND) begin
          tok_next.done = 1'b1;
          if (op == sptt_pkg::OP_ADD) coef_next = coef + coefficient;
          else valid_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      busy    <= 1'b0;
      tok_out <= '0;
    end else begin
      valid   <= valid_next;
      busy    <= busy_next;
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    coef     <= coef_next;
    deg      <= deg_next;
    r        <= r_next;
    b        <= b_next;
    e        <= e_next;
    pow_done <= pow_done_next;
    held     <= held_next;
  end

endmodule

### hdl/sptt_checker.sv
// ----------------------------------------------------------------------------
// sptt_checker: port-level checks of the term table
// Handshake rules and one-item-at-a-time behavior.
// ----------------------------------------------------------------------------
module sptt_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input sptt_pkg::in_beat_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input sptt_pkg::out_beat_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while result pending");

  a_stat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status != 2'd3)
    else $error("bad status code");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input beat changed");

endmodule

bind sparse_polynomial_term_table sptt_checker u_sptt_checker (.*);

### dv/sparse_polynomial_term_table_test.sv
// ----------------------------------------------------------------------------
// sparse_polynomial_term_table_test: self-checking bench of the term table
// Drives append, add, remove and evaluate beats under random idling, keeps a
// shadow table of terms and checks every result beat field by field.
// ----------------------------------------------------------------------------
module sparse_polynomial_term_table_test;

  localparam int NTERMS = 16;
  localparam int LIMIT  = 2000000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  sptt_pkg::in_beat_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  sptt_pkg::out_beat_t out_data;

  sparse_polynomial_term_table dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // shadow table
  logic [31:0] sh_coef [NTERMS];
  logic [7:0]  sh_deg  [NTERMS];
  logic        sh_used [NTERMS];
  int          sh_count;

  sptt_pkg::out_beat_t pending_results [$];
  int        errors;
  int        cycles;
  int        send_idle_pct;   // sender idle chance, percent
  int        recv_idle_pct;   // receiver stall chance, percent

  function automatic logic [31:0] ipow(logic [31:0] x, logic [7:0] e);
    logic [31:0] r;
    r = 32'd1;
    for (int k = 0; k < e; k++) r = r * x;
    return r;
  endfunction

  function automatic int lowest_match(logic [7:0] d);
    for (int k = 0; k < NTERMS; k++)
      if (sh_used[k] && sh_deg[k] == d) return k;
    return -1;
  endfunction

  function automatic logic [1:0] store_term(logic [31:0] c, logic [7:0] d);
    if (sh_count >= NTERMS) return sptt_pkg::ST_FULL;
    for (int k = 0; k < NTERMS; k++)
      if (!sh_used[k]) begin
        sh_used[k] = 1'b1; sh_coef[k] = c; sh_deg[k] = d; sh_count++;
        return sptt_pkg::ST_OK;
      end
    return sptt_pkg::ST_FULL;
  endfunction

  // next result of the table for one beat; updates the shadow state
  function automatic sptt_pkg::out_beat_t table_step(sptt_pkg::in_beat_t b);
    sptt_pkg::out_beat_t r;
    int        k;
    r = '0;
    case (sptt_pkg::op_t'(b.op))
      sptt_pkg::OP_APPEND: r.status = store_term(b.coefficient, b.degree);
      sptt_pkg::OP_ADD: begin
        k = lowest_match(b.degree);
        if (k >= 0) sh_coef[k] = sh_coef[k] + b.coefficient;
        else r.status = store_term(b.coefficient, b.degree);
      end
      sptt_pkg::OP_REMOVE: begin
        k = lowest_match(b.degree);
        if (k >= 0) begin
          sh_used[k] = 1'b0; sh_count--;
        end else begin
          r.status = sptt_pkg::ST_NOTFOUND;
        end
      end
      default: begin
        for (k = 0; k < NTERMS; k++)
          if (sh_used[k]) r.value = r.value + sh_coef[k] * ipow(b.point, sh_deg[k]);
      end
    endcase
    r.term_total = sh_count[4:0];
    return r;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random stall, check each accepted beat
  always @(posedge clk) begin
    sptt_pkg::out_beat_t exp_r;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", out_data);
      end else begin
        exp_r = pending_results.pop_front();
        if (out_data.value !== exp_r.value || out_data.status !== exp_r.status ||
            out_data.term_total !== exp_r.term_total) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp value %h status %0d total %0d, got %h %0d %0d",
                     exp_r.value, exp_r.status, exp_r.term_total,
                     out_data.value, out_data.status, out_data.term_total);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // one beat: optional idle gap, then hold until accepted
  task automatic send_beat(sptt_pkg::op_t o, logic [31:0] c, logic [7:0] d,
                           logic [31:0] x);
    sptt_pkg::in_beat_t b;
    b.op = o; b.coefficient = c; b.degree = d; b.point = x;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(table_step(b));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] rand_degree;
    case ($urandom_range(3))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'($urandom_range(7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] rand_word;
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'($urandom_range(7)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  // extremes, full table, missing degree, zero power
  task automatic test_directed;
    send_beat(sptt_pkg::OP_EVAL, 32'd0, 8'd0, 32'd5);            // empty table
    send_beat(sptt_pkg::OP_APPEND, 32'h7fff_ffff, 8'd0, 32'd0);
    send_beat(sptt_pkg::OP_EVAL, 32'd0, 8'd0, 32'd0);            // x^0 is 1 at x = 0
    send_beat(sptt_pkg::OP_APPEND, 32'h8000_0000, 8'd255, 32'd0);
    send_beat(sptt_pkg::OP_EVAL, 32'd0, 8'd0, 32'hffff_ffff);
    send_beat(sptt_pkg::OP_ADD, 32'd3, 8'd255, 32'd0);           // merge
    send_beat(sptt_pkg::OP_ADD, 32'd7, 8'd9, 32'd0);             // no match, appends
    send_beat(sptt_pkg::OP_REMOVE, 32'd0, 8'd100, 32'd0);        // degree not found
    send_beat(sptt_pkg::OP_REMOVE, 32'd0, 8'd255, 32'd0);
    for (int k = 0; k < 15; k++)
      send_beat(sptt_pkg::OP_APPEND, $urandom, 8'(k), 32'd0);
    send_beat(sptt_pkg::OP_ADD, 32'd1, 8'd200, 32'd0);           // table full
    send_beat(sptt_pkg::OP_EVAL, 32'd0, 8'd0, 32'h8000_0000);
  endtask

  task automatic test_clear_table;
    for (int k = 0; k < 256 && sh_count > 0; k++)
      while (lowest_match(8'(k)) >= 0)
        send_beat(sptt_pkg::OP_REMOVE, 32'd0, 8'(k), 32'd0);
  endtask

  // random mix of ops, degrees mostly low or at the extremes, some noise
  task automatic test_random(int n);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 30)
        send_beat(sptt_pkg::OP_APPEND, rand_word(), rand_degree(), $urandom);
      else if (r < 55)
        send_beat(sptt_pkg::OP_ADD, rand_word(), rand_degree(), $urandom);
      else if (r < 75)
        send_beat(sptt_pkg::OP_REMOVE, $urandom, rand_degree(), $urandom);
      else
        send_beat(sptt_pkg::OP_EVAL, $urandom, 8'($urandom), rand_word());
      if (k == n / 2) drain;                     // sender holds off
    end
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    send_idle_pct = 13;
    recv_idle_pct = 53;
    for (int k = 0; k < NTERMS; k++) begin
      sh_used[k] = 1'b0; sh_coef[k] = '0; sh_deg[k] = '0;
    end
    sh_count = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_clear_table();
    test_random(600);
    send_idle_pct = 53;
    recv_idle_pct = 13;
    test_random(600);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(600);
    drain;
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
